// ----- hdl/picc_pkg.sv -----
`default_nettype none
package picc_pkg;

    localparam int unsigned DEF_NUM_SOURCES = 1023;
    localparam int unsigned DEF_NUM_TARGETS = 16;

    localparam int unsigned ACTION_W = 4;
    localparam int unsigned TARGET_W = 4;
    localparam int unsigned SOURCE_W = 10;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SETPRIO  = 4'd0,
        ACT_CLRPRIO  = 4'd1,
        ACT_RDPEND   = 4'd2,
        ACT_SETPEND  = 4'd3,
        ACT_ENABLE   = 4'd4,
        ACT_DISABLE  = 4'd5,
        ACT_RDENABLE = 4'd6,
        ACT_SETTHRES = 4'd7,
        ACT_RDTHRES  = 4'd8,
        ACT_CLAIM    = 4'd9,
        ACT_COMPLETE = 4'd10
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_CLAIM_WB,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

// ----- hdl/platform_interrupt_claim_controller.sv -----
`default_nettype none
// Interrupt claim controller: one request in, one response out. Per-source priority,
// pending and the per-target enable bits of a source share one word of a single
// synchronous memory (NUM_SOURCES+1 words); thresholds live in flops. The block works
// on one request at a time: threshold and unused actions go straight to respond,
// priority, pending and enable actions pass read, modify/write back and respond,
// and a claim scans the sources, reading one memory word per cycle through the
// single read port, then clears the winner's pending bit. After reset a clearing pass
// zeroes the memory, during which s_tready stays low. A finished response waits in
// the output register; an out-of-range source or target returns error with read_value 0.
module platform_interrupt_claim_controller #(
    parameter int unsigned NUM_SOURCES = picc_pkg::DEF_NUM_SOURCES,
    parameter int unsigned NUM_TARGETS = picc_pkg::DEF_NUM_TARGETS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // action[3:0], target[7:4], source[17:8], value[33:18], zero pad
    input  wire logic [picc_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // read_value[15:0], error[16], zero pad
    output logic [picc_pkg::OUT_W-1:0]      m_tdata
);
    import picc_pkg::*;

    localparam int unsigned SRC_SLOTS = NUM_SOURCES + 1;
    localparam int unsigned AW  = (SRC_SLOTS > 1) ? $clog2(SRC_SLOTS) : 1;
    localparam int unsigned TW  = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    // memory word: {priority, pending, enable per target}
    localparam int unsigned WW  = PRIO_W + 1 + NUM_TARGETS;
    localparam int unsigned PND = NUM_TARGETS;

    state_t state_reg, state_next;

    // memory
    logic [WW-1:0] mem [SRC_SLOTS];
    logic [WW-1:0] rd_data_reg;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;

    // captured request
    action_t              act_reg;
    logic [TW-1:0]        tgt_reg;
    logic [AW-1:0]        src_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [VALUE_W-1:0]   res_val_reg;
    logic                 res_err_reg;

    logic [VALUE_W-1:0]   thr_reg [NUM_TARGETS];

    // clearing pass and scan
    logic [AW-1:0]        clr_addr_reg;
    logic [AW:0]          scan_addr_reg;
    logic                 chk_vld_reg;
    logic [AW-1:0]        chk_addr_reg;
    logic [AW-1:0]        best_id_reg;
    logic [PRIO_W-1:0]    best_prio_reg;
    logic [WW-1:0]        best_word_reg;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_val_reg;
    logic                 out_err_reg;

    // incoming request fields
    logic                 accept;
    action_t              in_act;
    logic [TARGET_W-1:0]  in_tgt;
    logic [SOURCE_W-1:0]  in_src;
    logic [VALUE_W-1:0]   in_val;
    logic                 src_ok;
    logic                 tgt_ok;
    logic                 in_err;

    logic                 clr_done;
    logic                 scan_issue;
    logic                 scan_done;
    logic                 candidate;
    logic                 resp_load;
    logic [WW-1:0]        rmw_word;
    logic                 rmw_write;
    logic [VALUE_W-1:0]   rmw_res;

    assign in_act = action_t'(s_tdata[3:0]);
    assign in_tgt = s_tdata[7:4];
    assign in_src = s_tdata[17:8];
    assign in_val = s_tdata[33:18];

    assign src_ok = (in_src != '0) && (in_src <= SOURCE_W'(NUM_SOURCES));
    assign tgt_ok = ({1'b0, in_tgt} < (TARGET_W + 1)'(NUM_TARGETS));

    always_comb
    begin
        unique case (in_act)
            ACT_SETPRIO, ACT_CLRPRIO, ACT_RDPEND, ACT_SETPEND:
                in_err = !src_ok;
            ACT_ENABLE, ACT_DISABLE, ACT_RDENABLE:
                in_err = !src_ok || !tgt_ok;
            ACT_SETTHRES, ACT_RDTHRES, ACT_CLAIM, ACT_COMPLETE:
                in_err = !tgt_ok;
            default:
                in_err = 1'b0;
        endcase
    end

    assign accept     = s_tvalid && s_tready;
    assign clr_done   = (clr_addr_reg == AW'(SRC_SLOTS - 1));
    assign scan_issue = (scan_addr_reg <= (AW + 1)'(NUM_SOURCES));
    assign scan_done  = !scan_issue && !chk_vld_reg;
    assign resp_load  = !out_valid_reg || m_tready;

    // candidate for a claim: pending, enabled, above threshold, strictly above best
    assign candidate = chk_vld_reg && rd_data_reg[PND] && rd_data_reg[tgt_reg]
        && ({{(VALUE_W - PRIO_W){1'b0}}, rd_data_reg[WW-1 -: PRIO_W]} > thr_reg[tgt_reg])
        && (rd_data_reg[WW-1 -: PRIO_W] > best_prio_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_done)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    if (in_err)
                        state_next = ST_RESP;
                    else
                    begin
                        unique case (in_act)
                            ACT_SETPRIO, ACT_CLRPRIO, ACT_RDPEND, ACT_SETPEND,
                            ACT_ENABLE, ACT_DISABLE, ACT_RDENABLE:
                                state_next = ST_RMW;
                            ACT_CLAIM:
                                state_next = ST_SCAN;
                            default:
                                state_next = ST_RESP;
                        endcase
                    end
                end
            ST_RMW:
                state_next = ST_RESP;
            ST_SCAN:
                if (scan_done)
                    state_next = ST_CLAIM_WB;
            ST_CLAIM_WB:
                state_next = ST_RESP;
            ST_RESP:
                if (resp_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // read-modify-write of one memory word
    always_comb
    begin
        rmw_word  = rd_data_reg;
        rmw_write = 1'b0;
        rmw_res   = '0;
        unique case (act_reg)
            ACT_SETPRIO:
            begin
                rmw_word[WW-1 -: PRIO_W] = val_reg[PRIO_W-1:0];
                rmw_write = 1'b1;
            end
            ACT_CLRPRIO:
            begin
                rmw_word[WW-1 -: PRIO_W] = '0;
                rmw_write = 1'b1;
            end
            ACT_RDPEND:
                rmw_res = {{(VALUE_W - 1){1'b0}}, rd_data_reg[PND]};
            ACT_SETPEND:
            begin
                rmw_word[PND] = 1'b1;
                rmw_write = 1'b1;
            end
            ACT_ENABLE:
            begin
                rmw_word[tgt_reg] = 1'b1;
                rmw_write = 1'b1;
            end
            ACT_DISABLE:
            begin
                rmw_word[tgt_reg] = 1'b0;
                rmw_write = 1'b1;
            end
            ACT_RDENABLE:
                rmw_res = {{(VALUE_W - 1){1'b0}}, rd_data_reg[tgt_reg]};
            default:
                rmw_res = '0;
        endcase
    end

    // outputs and memory control
    always_comb
    begin
        s_tready = 1'b0;
        mem_re   = 1'b0;
        mem_ra   = scan_addr_reg[AW-1:0];
        mem_we   = 1'b0;
        mem_wa   = src_reg;
        mem_wd   = rmw_word;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = '0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                mem_re   = accept;
                mem_ra   = in_src[AW-1:0];
            end
            ST_RMW:
                mem_we = rmw_write;
            ST_SCAN:
                mem_re = scan_issue;
            ST_CLAIM_WB:
            begin
                // claimed source loses its pending bit
                mem_we = (best_id_reg != '0);
                mem_wa = best_id_reg;
                mem_wd = best_word_reg & ~({{(WW - 1){1'b0}}, 1'b1} << PND);
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            chk_vld_reg <= (state_reg == ST_SCAN) && scan_issue;
            if (state_reg == ST_RESP && resp_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_addr_reg <= scan_addr_reg[AW-1:0];
        if (accept)
        begin
            act_reg       <= in_act;
            tgt_reg       <= in_tgt[TW-1:0];
            src_reg       <= in_src[AW-1:0];
            val_reg       <= in_val;
            res_err_reg   <= in_err;
            res_val_reg   <= (!in_err && in_act == ACT_RDTHRES) ?
                             thr_reg[in_tgt[TW-1:0]] : '0;
            scan_addr_reg <= (AW + 1)'(1);
            best_id_reg   <= '0;
            best_prio_reg <= '0;
            if (!in_err && in_act == ACT_SETTHRES)
                thr_reg[in_tgt[TW-1:0]] <= in_val;
        end
        if (state_reg == ST_CLEAR)
        begin
            for (int i = 0; i < NUM_TARGETS; i++)
                thr_reg[i] <= '0;
        end
        if (state_reg == ST_RMW)
            res_val_reg <= rmw_res;
        if (state_reg == ST_SCAN)
        begin
            if (scan_issue)
                scan_addr_reg <= scan_addr_reg + (AW + 1)'(1);
            if (candidate)
            begin
                best_id_reg   <= chk_addr_reg;
                best_prio_reg <= rd_data_reg[WW-1 -: PRIO_W];
                best_word_reg <= rd_data_reg;
            end
        end
        if (state_reg == ST_CLAIM_WB)
            res_val_reg <= VALUE_W'(best_id_reg);
        if (state_reg == ST_RESP && resp_load)
        begin
            out_val_reg <= res_val_reg;
            out_err_reg <= res_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - VALUE_W - 1){1'b0}}, out_err_reg, out_val_reg};

endmodule
`default_nettype wire

// ----- hdl/picc_checker.sv -----
`default_nettype none
module picc_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic [picc_pkg::IN_W-1:0] s_tdata,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [picc_pkg::OUT_W-1:0] m_tdata
);

    // response held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("response dropped while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && !s_tready)
        else $error("handshake active during reset");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("error response carries data");

endmodule

bind platform_interrupt_claim_controller picc_checker u_picc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import picc_pkg::*;

    localparam int NSRC = DEF_NUM_SOURCES;
    localparam int NTGT = DEF_NUM_TARGETS;

    typedef struct packed {
        logic        err;
        logic [15:0] rd;
    } resp_t;

    typedef struct {
        logic [3:0]  act;
        logic [3:0]  tgt;
        logic [9:0]  src;
        logic [15:0] val;
        bit          typed;
        resp_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    platform_interrupt_claim_controller i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow copy of the controller state
    logic [7:0]  prio_q [0:1023];
    bit          pend_q [0:1023];
    bit          en_q   [0:15][0:1023];
    logic [15:0] thres_q [0:15];
    logic [9:0]  ccid_q  [0:15];

    resp_t resp_q[$];
    int    errors = 0;
    int    send_idle = 32;
    int    recv_idle = 71;
    bit    hold_recv = 1'b0;
    bit    stim_done = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic resp_t predict_access(logic [3:0] a, logic [3:0] t,
                                             logic [9:0] s, logic [15:0] v);
        resp_t r;
        int best;
        int bp;
        bit sok;
        r = '0;
        sok = (s >= 1) && (s <= NSRC);
        case (a)
            ACT_SETPRIO, ACT_CLRPRIO, ACT_RDPEND, ACT_SETPEND:
            begin
                if (!sok) r.err = 1'b1;
                else if (a == ACT_SETPRIO) prio_q[s] = v[7:0];
                else if (a == ACT_CLRPRIO) prio_q[s] = '0;
                else if (a == ACT_RDPEND) r.rd = 16'(pend_q[s]);
                else pend_q[s] = 1'b1;
            end
            ACT_ENABLE, ACT_DISABLE, ACT_RDENABLE:
            begin
                if (!sok || t >= NTGT) r.err = 1'b1;
                else if (a == ACT_ENABLE) en_q[t][s] = 1'b1;
                else if (a == ACT_DISABLE) en_q[t][s] = 1'b0;
                else r.rd = 16'(en_q[t][s]);
            end
            ACT_SETTHRES, ACT_RDTHRES, ACT_CLAIM, ACT_COMPLETE:
            begin
                if (t >= NTGT) r.err = 1'b1;
                else if (a == ACT_SETTHRES) thres_q[t] = v;
                else if (a == ACT_RDTHRES) r.rd = thres_q[t];
                else if (a == ACT_COMPLETE) ccid_q[t] = v[9:0];
                else
                begin
                    best = 0;
                    bp = 0;
                    for (int i = 1; i <= NSRC; i++)
                        if (pend_q[i] && en_q[t][i] && prio_q[i] > thres_q[t]
                            && prio_q[i] > bp)
                        begin
                            best = i;
                            bp = prio_q[i];
                        end
                    if (best != 0)
                    begin
                        pend_q[best] = 1'b0;
                        ccid_q[t] = 10'(best);
                    end
                    r.rd = 16'(best);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one request, waiting out random idle cycles and the handshake
    task automatic send_request(logic [3:0] a, logic [3:0] t, logic [9:0] s,
                                logic [15:0] v, bit typed, resp_t want);
        resp_t p;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, v, s, t, a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        p = predict_access(a, t, s, v);
        if (typed && p != want)
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, want, p);
        resp_q.push_back(typed ? want : p);
    endtask

    // response checker and receiver idling
    always @(posedge clk)
    begin
        resp_t got;
        resp_t exp_r;
        if (m_tvalid && m_tready)
        begin
            got = resp_t'(m_tdata[16:0]);
            if (resp_q.size() == 0)
            begin
                $display("%0t unexpected response: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = resp_q.pop_front();
                if (got.rd !== exp_r.rd)
                begin
                    $display("%0t read_value: expected %h actual %h", $time, exp_r.rd, got.rd);
                    errors++;
                end
                if (got.err !== exp_r.err)
                begin
                    $display("%0t error: expected %b actual %b", $time, exp_r.err, got.err);
                    errors++;
                end
            end
        end
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    // long receiver hold-off so the block backs up
    initial begin
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
    end

    row_t tbl[$];

    function automatic row_t mk(logic [3:0] a, logic [3:0] t, logic [9:0] s,
                                logic [15:0] v, bit typed, logic [15:0] rd, bit e);
        row_t r;
        r.act = a; r.tgt = t; r.src = s; r.val = v; r.typed = typed;
        r.want.rd = rd; r.want.err = e;
        return r;
    endfunction

    initial begin
        int wait_cnt;
        logic [3:0] a;
        logic [3:0] t;
        logic [9:0] s;
        logic [15:0] v;
        int seq;
        for (int i = 0; i < 1024; i++)
        begin
            prio_q[i] = '0;
            pend_q[i] = 1'b0;
            for (int j = 0; j < 16; j++) en_q[j][i] = 1'b0;
        end
        for (int j = 0; j < 16; j++)
        begin
            thres_q[j] = '0;
            ccid_q[j] = '0;
        end
        // directed table: reset reads, extremes, error codes, then predicted rows
        tbl.push_back(mk(ACT_RDTHRES, 4'd15, 10'd0, 16'd0, 1, 16'd0, 0));
        tbl.push_back(mk(ACT_CLAIM, 4'd0, 10'd0, 16'd0, 1, 16'd0, 0));
        tbl.push_back(mk(ACT_RDPEND, 4'd0, 10'd1023, 16'd0, 1, 16'd0, 0));
        tbl.push_back(mk(ACT_SETPRIO, 4'd0, 10'd0, 16'hFFFF, 1, 16'd0, 1));
        tbl.push_back(mk(ACT_SETPEND, 4'd0, 10'd0, 16'd0, 1, 16'd0, 1));
        tbl.push_back(mk(ACT_RDENABLE, 4'd3, 10'd0, 16'd0, 1, 16'd0, 1));
        tbl.push_back(mk(4'd11, 4'd0, 10'd5, 16'd5, 1, 16'd0, 0));
        tbl.push_back(mk(4'd15, 4'd15, 10'h3FF, 16'hFFFF, 1, 16'd0, 0));
        tbl.push_back(mk(ACT_SETPRIO, 4'd0, 10'd1, 16'hFF07, 0, 0, 0));
        tbl.push_back(mk(ACT_SETPRIO, 4'd0, 10'd1, 16'h0003, 0, 0, 0));
        tbl.push_back(mk(ACT_SETPRIO, 4'd0, 10'd1023, 16'h00FF, 0, 0, 0));
        tbl.push_back(mk(ACT_SETPRIO, 4'd0, 10'd500, 16'h00FF, 0, 0, 0));
        tbl.push_back(mk(ACT_SETPEND, 4'd0, 10'd1, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_SETPEND, 4'd0, 10'd500, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_SETPEND, 4'd0, 10'd1023, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_ENABLE, 4'd15, 10'd1023, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_ENABLE, 4'd15, 10'd500, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_ENABLE, 4'd15, 10'd1, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_RDENABLE, 4'd15, 10'd1, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_CLAIM, 4'd15, 10'd0, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_DISABLE, 4'd15, 10'd1023, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_SETTHRES, 4'd15, 10'd0, 16'hFFFF, 0, 0, 0));
        tbl.push_back(mk(ACT_CLAIM, 4'd15, 10'd0, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_SETTHRES, 4'd15, 10'd0, 16'd2, 0, 0, 0));
        tbl.push_back(mk(ACT_CLAIM, 4'd15, 10'd0, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_COMPLETE, 4'd15, 10'd0, 16'hFFFF, 0, 0, 0));
        tbl.push_back(mk(ACT_RDPEND, 4'd0, 10'd1, 16'd0, 0, 0, 0));
        tbl.push_back(mk(ACT_CLRPRIO, 4'd0, 10'd1, 16'd0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (tbl[i])
            send_request(tbl[i].act, tbl[i].tgt, tbl[i].src, tbl[i].val,
                         tbl[i].typed, tbl[i].want);

        // random part in three idling phases; mostly set-up-and-claim sequences
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1) begin send_idle = 71; recv_idle = 32; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            for (int n = 0; n < 190; n++)
            begin
                seq = $urandom_range(9);
                t = 4'($urandom_range(15));
                s = 10'($urandom_range(1, 24));
                if (seq < 7)
                begin
                    // well formed: mostly priority, pending, enable, claim or threshold, picked at random
                    case ($urandom_range(5))
                        0: a = ACT_SETPRIO;
                        1: a = ACT_SETPEND;
                        2: a = ACT_ENABLE;
                        3: a = ACT_CLAIM;
                        4: a = ACT_SETTHRES;
                        default: a = 4'($urandom_range(10));
                    endcase
                    v = (a == ACT_SETTHRES) ? 16'($urandom_range(6))
                                            : 16'($urandom);
                    if (a == ACT_SETPRIO) v[7:0] = 8'($urandom_range(1, 12));
                end
                else
                begin
                    a = 4'($urandom);
                    t = 4'($urandom);
                    s = 10'($urandom);
                    v = 16'($urandom);
                end
                send_request(a, t, s, v, 0, '0);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        wait_cnt = 0;
        while (resp_q.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (2100) @(posedge clk);
        if (errors == 0 && resp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
